// ===== rtl/astw_pkg.sv =====
// ----------------------------------------------------------------------------
// astw_pkg
// Shared types, constants and the arctangent table for the steering block.
// ----------------------------------------------------------------------------
package astw_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int NSTG         = CORDIC_STEPS + 3;

    localparam int SPEED_W = 16;
    localparam int RATE_W  = 16;
    localparam int ANGLE_W = 16;
    localparam int MAXA_W  = 15;
    localparam int WB_W    = 14;
    localparam int CFG_W   = 15;
    localparam int IDX_W   = 1;
    localparam int DATA_W  = 32;

    localparam int FRAC_SH = 30;
    localparam int XMAG_W  = 28;
    localparam int YMAG_W  = 30;
    localparam int XW      = 62;
    localparam int ZW      = 62;
    localparam int RND_SH  = 46;
    localparam int MAG_W   = 15;

    localparam logic [MAG_W-1:0]  HALF_PI_Q14     = 15'd25736;
    localparam logic [MAXA_W-1:0] MAX_ANGLE_RESET = 15'd16384;
    localparam logic [WB_W-1:0]   WHEELBASE_RESET = 14'd1454;
    localparam logic [63:0]       PI_QUARTER_Q60  = 64'h0C90FDAA22168C23;

    localparam logic [IDX_W-1:0] REG_MAX_ANGLE = 1'd0;
    localparam logic [IDX_W-1:0] REG_WHEELBASE = 1'd1;

    typedef struct packed {
        logic signed [SPEED_W-1:0] speed;
        logic                      prod_zero;
        logic                      speed_zero;
        logic                      neg;
    } side_t;

    // atan(2^-i) in Q60 from the truncated odd power series, pi/4 constant for i = 0
    function automatic logic [63:0] atan_q60(input int unsigned i);
        logic [63:0] acc;
        logic [63:0] term;
        int unsigned e;
        acc = 64'd0;
        if (i == 0)
        begin
            acc = PI_QUARTER_Q60;
        end
        else
        begin
            for (int unsigned k = 0; i * (2 * k + 1) <= 60; k++)
            begin
                e    = i * (2 * k + 1);
                term = (64'd1 << (60 - e)) / 64'(2 * k + 1);
                if (k[0])
                    acc = acc - term;
                else
                    acc = acc + term;
            end
        end
        return acc;
    endfunction

endpackage

// ===== rtl/ackermann_steering_from_twist.sv =====
// ----------------------------------------------------------------------------
// ackermann_steering_from_twist
// Steering angle atan(rate * wheelbase / speed) from a twist command, speed
// passed through. Vectoring CORDIC, one iteration per pipeline stage.
// ----------------------------------------------------------------------------
// path: input beat passes stage a, stage b, the cordic stages, the rounding stage, then the output buffer
// throughput: one beat per cycle while the skid entry is empty, set by the fully unrolled cordic pipeline
// a two-entry output buffer lets input flow while one result waits
// reset: async active low, clears pipeline and buffer valid bits, loads register
// defaults (max_angle 16384, wheelbase 1454)
module ackermann_steering_from_twist (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [astw_pkg::IDX_W-1:0]  cfg_addr,
    input  logic [astw_pkg::CFG_W-1:0]  cfg_data,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [astw_pkg::DATA_W-1:0] s_tdata,  // linear_speed, angular_rate
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [astw_pkg::DATA_W-1:0] m_tdata   // drive_speed, wheel_angle
);
    import astw_pkg::*;

    logic [MAXA_W-1:0] max_angle_reg;
    logic [WB_W-1:0]   wheelbase_reg;
    logic [NSTG-1:0]   vld_reg;
    logic              en;
    logic              push;

    // stage a
    logic [SPEED_W-1:0] a_wm_reg;
    logic [SPEED_W-1:0] a_vm_reg;
    logic               a_wzero_reg;
    side_t              a_side_reg;
    logic signed [SPEED_W-1:0] in_v;
    logic signed [RATE_W-1:0]  in_w;

    // stage b
    logic [XMAG_W-1:0] b_xmag_reg;
    logic [YMAG_W-1:0] b_ymag_reg;
    side_t             b_side_reg;

    // cordic stages
    logic signed [XW-1:0] cx_reg [CORDIC_STEPS];
    logic signed [XW-1:0] cy_reg [CORDIC_STEPS];
    logic signed [ZW-1:0] cz_reg [CORDIC_STEPS];
    side_t                cs_reg [CORDIC_STEPS];

    // rounding stage
    logic [MAG_W-1:0]     r_mag_reg;
    side_t                r_side_reg;
    logic [MAG_W-1:0]     r_mag_next;
    logic signed [ZW-1:0] z_rnd;
    logic signed [ZW-RND_SH-1:0] z_q14;

    // output buffer
    logic [MAXA_W-1:0]         lim;
    logic signed [ANGLE_W-1:0] ang;
    logic [DATA_W-1:0]         res;
    logic [DATA_W-1:0]         out_reg;
    logic [DATA_W-1:0]         skid_reg;
    logic                      out_vld_reg;
    logic                      skid_vld_reg;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_angle_reg <= MAX_ANGLE_RESET;
            wheelbase_reg <= WHEELBASE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_MAX_ANGLE: max_angle_reg <= cfg_data[MAXA_W-1:0];
                REG_WHEELBASE: wheelbase_reg <= cfg_data[WB_W-1:0];
                default: ;
            endcase
        end
    end

    assign en       = !skid_vld_reg;
    assign s_tready = en;
    assign push     = en && vld_reg[NSTG-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[NSTG-2:0], s_tvalid};
    end

    // stage a: magnitudes and signs
    assign in_v = s_tdata[SPEED_W-1:0];
    assign in_w = s_tdata[SPEED_W+RATE_W-1:SPEED_W];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_wm_reg              <= in_w[RATE_W-1] ? SPEED_W'(-in_w) : SPEED_W'(in_w);
            a_vm_reg              <= in_v[SPEED_W-1] ? SPEED_W'(-in_v) : SPEED_W'(in_v);
            a_wzero_reg           <= (in_w == '0);
            a_side_reg.speed      <= in_v;
            a_side_reg.prod_zero  <= 1'b0;
            a_side_reg.speed_zero <= (in_v == '0);
            a_side_reg.neg        <= in_w[RATE_W-1] ^ in_v[SPEED_W-1];
        end
    end

    // stage b: y = |w| * wheelbase, x = |v| * 4096
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b_ymag_reg            <= YMAG_W'(a_wm_reg * wheelbase_reg);
            b_xmag_reg            <= {a_vm_reg, 12'd0};
            b_side_reg.speed      <= a_side_reg.speed;
            b_side_reg.speed_zero <= a_side_reg.speed_zero;
            b_side_reg.neg        <= a_side_reg.neg;
            b_side_reg.prod_zero  <= a_wzero_reg || (wheelbase_reg == '0);
        end
    end

    // cordic: one vectoring iteration per stage
    for (genvar g = 0; g < CORDIC_STEPS; g++)
    begin : g_cordic
        localparam logic signed [ZW-1:0] ATAN = ZW'(atan_q60(g));
        logic signed [XW-1:0] x_in;
        logic signed [XW-1:0] y_in;
        logic signed [ZW-1:0] z_in;
        side_t                s_in;
        logic signed [XW-1:0] xs;
        logic signed [XW-1:0] ys;

        if (g == 0)
        begin : g_first
            assign x_in = XW'({b_xmag_reg, FRAC_SH'(0)});
            assign y_in = XW'({b_ymag_reg, FRAC_SH'(0)});
            assign z_in = '0;
            assign s_in = b_side_reg;
        end
        else
        begin : g_next
            assign x_in = cx_reg[g-1];
            assign y_in = cy_reg[g-1];
            assign z_in = cz_reg[g-1];
            assign s_in = cs_reg[g-1];
        end

        assign xs = x_in >>> g;
        assign ys = y_in >>> g;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                cs_reg[g] <= s_in;
                if (!y_in[XW-1])
                begin
                    cx_reg[g] <= x_in + ys;
                    cy_reg[g] <= y_in - xs;
                    cz_reg[g] <= z_in + ATAN;
                end
                else
                begin
                    cx_reg[g] <= x_in - ys;
                    cy_reg[g] <= y_in + xs;
                    cz_reg[g] <= z_in - ATAN;
                end
            end
        end
    end

    // rounding to q2.14 and special cases
    assign z_rnd = cz_reg[CORDIC_STEPS-1] + (ZW'(1) <<< (RND_SH - 1));
    assign z_q14 = z_rnd[ZW-1:RND_SH];

    always_comb
    begin
        if (z_q14 < 0)
            r_mag_next = '0;
        else if (z_q14 > $signed({1'b0, HALF_PI_Q14}))
            r_mag_next = HALF_PI_Q14;
        else
            r_mag_next = z_q14[MAG_W-1:0];
        if (cs_reg[CORDIC_STEPS-1].prod_zero)
            r_mag_next = '0;
        else if (cs_reg[CORDIC_STEPS-1].speed_zero)
            r_mag_next = HALF_PI_Q14;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_mag_reg  <= r_mag_next;
            r_side_reg <= cs_reg[CORDIC_STEPS-1];
        end
    end

    // limit and sign
    assign lim = (r_mag_reg > max_angle_reg) ? max_angle_reg : r_mag_reg;
    assign ang = r_side_reg.neg ? -$signed({1'b0, lim}) : $signed({1'b0, lim});
    assign res = {ang, r_side_reg.speed};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end
        else if (!out_vld_reg || m_tready)
        begin
            if (skid_vld_reg)
            begin
                out_vld_reg  <= 1'b1;
                skid_vld_reg <= 1'b0;
            end
            else
            begin
                out_vld_reg <= push;
            end
        end
        else if (push)
        begin
            skid_vld_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_vld_reg || m_tready)
        begin
            out_reg <= skid_vld_reg ? skid_reg : res;
        end
        else if (push)
        begin
            skid_reg <= res;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_reg;

endmodule

// ===== rtl/astw_checker.sv =====
// ----------------------------------------------------------------------------
// astw_checker
// Port-level checks for the steering block, bound to the top level.
// ----------------------------------------------------------------------------
module astw_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        cfg_we,
    input logic [astw_pkg::IDX_W-1:0]  cfg_addr,
    input logic [astw_pkg::CFG_W-1:0]  cfg_data,
    input logic                        s_tvalid,
    input logic                        s_tready,
    input logic [astw_pkg::DATA_W-1:0] s_tdata,
    input logic                        m_tvalid,
    input logic                        m_tready,
    input logic [astw_pkg::DATA_W-1:0] m_tdata
);
    import astw_pkg::*;

    logic [MAXA_W-1:0]         max_angle_reg;
    logic signed [ANGLE_W-1:0] ang;
    logic [ANGLE_W-1:0]        ang_mag;
    logic signed [SPEED_W-1:0] in_speed;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_angle_reg <= MAX_ANGLE_RESET;
        else if (cfg_we && cfg_addr == REG_MAX_ANGLE)
            max_angle_reg <= cfg_data[MAXA_W-1:0];
    end

    assign ang      = m_tdata[SPEED_W+ANGLE_W-1:SPEED_W];
    assign ang_mag  = ang[ANGLE_W-1] ? ANGLE_W'(-ang) : ANGLE_W'(ang);
    assign in_speed = s_tdata[SPEED_W-1:0];

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output beat changed while stalled");

    // angle within limit
    a_angle_limit: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (ang_mag <= ANGLE_W'(max_angle_reg)) &&
                     (ang_mag <= ANGLE_W'(HALF_PI_Q14)))
        else $error("steering angle beyond limit");

    // input only refused while results are waiting
    a_ready_back: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid && !$past(m_tready))
        else $error("input refused without a waiting result");

    // zero limit gives zero angle
    a_zero_limit: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && max_angle_reg == '0 |-> ang == '0)
        else $error("nonzero angle with zero limit");

    logic unused_in;
    assign unused_in = s_tvalid ^ (^in_speed);

endmodule

bind ackermann_steering_from_twist astw_checker u_astw_checker (.*);
